[rtl/vfv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants for the voxel face visibility core.
// ----------------------------------------------------------------------------
package vfv_pkg;

   localparam int CoordW = 5;
   localparam int MatW   = 16;
   localparam int MaskW  = 6;
   localparam int StepW  = 3;
   // coordinate compare width, holds GRID_SIZE up to 255
   localparam int CmpW   = 8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // read sequence of a query: center first, then the six neighbors
   localparam logic [StepW-1:0] STEP_CENTER = 3'd0;
   localparam logic [StepW-1:0] STEP_POS_Z  = 3'd1;
   localparam logic [StepW-1:0] STEP_NEG_Z  = 3'd2;
   localparam logic [StepW-1:0] STEP_POS_X  = 3'd3;
   localparam logic [StepW-1:0] STEP_NEG_X  = 3'd4;
   localparam logic [StepW-1:0] STEP_POS_Y  = 3'd5;
   localparam logic [StepW-1:0] STEP_NEG_Y  = 3'd6;
   localparam logic [StepW-1:0] STEP_LAST   = STEP_NEG_Y;

   localparam logic [MaskW-1:0] FACE_ALL   = 6'd63;
   localparam logic [MaskW-1:0] FACE_POS_Z = 6'd32;
   localparam logic [MaskW-1:0] FACE_NEG_Z = 6'd16;
   localparam logic [MaskW-1:0] FACE_POS_X = 6'd8;
   localparam logic [MaskW-1:0] FACE_NEG_X = 6'd4;
   localparam logic [MaskW-1:0] FACE_POS_Y = 6'd2;
   localparam logic [MaskW-1:0] FACE_NEG_Y = 6'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic              ready;
      logic              load_query;
      logic              write_voxel;
      logic              clear_wr;
      logic              rd_en;
      logic [StepW-1:0]  rd_step;
      logic              rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

[rtl/vfv_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_req_if
// Request channel: voxel write or face query beats.
// ----------------------------------------------------------------------------
interface vfv_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [vfv_pkg::CoordW-1:0]  pos_x;
   logic [vfv_pkg::CoordW-1:0]  pos_y;
   logic [vfv_pkg::CoordW-1:0]  pos_z;
   logic [vfv_pkg::MatW-1:0]    material;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, material, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, pos_z, material, output ready);
endinterface

[rtl/vfv_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_rsp_if
// Response channel: exposed face mask and material of a queried voxel.
// ----------------------------------------------------------------------------
interface vfv_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vfv_pkg::MaskW-1:0]   face_mask;
   logic [vfv_pkg::MatW-1:0]    voxel_material;
   logic                        visible;

   modport source (output valid, face_mask, voxel_material, visible, input ready);
   modport sink   (input valid, face_mask, voxel_material, visible, output ready);
endinterface

[rtl/vfv_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_datapath
// Voxel store, neighbor address generation, face mask build and result register.
// ----------------------------------------------------------------------------
module vfv_datapath #(
   parameter int GRID_SIZE = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vfv_pkg::ctrl_cmd_type         cmd,
   output vfv_pkg::ctrl_status_type      status,
   input  logic [vfv_pkg::CoordW-1:0]    req_pos_x,
   input  logic [vfv_pkg::CoordW-1:0]    req_pos_y,
   input  logic [vfv_pkg::CoordW-1:0]    req_pos_z,
   input  logic [vfv_pkg::MatW-1:0]      req_material,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [vfv_pkg::MaskW-1:0]     rsp_face_mask,
   output logic [vfv_pkg::MatW-1:0]      rsp_voxel_material,
   output logic                          rsp_visible
);

   localparam int CW    = $clog2(GRID_SIZE);
   localparam int AW    = 3 * CW;
   localparam int Depth = 1 << AW;
   localparam logic [vfv_pkg::CmpW-1:0] GridC = vfv_pkg::CmpW'(GRID_SIZE);
   localparam logic [vfv_pkg::CmpW-1:0] LastC = vfv_pkg::CmpW'(GRID_SIZE - 1);
   localparam logic [CW-1:0]            One   = CW'(1);

   logic [vfv_pkg::MatW-1:0] mem [Depth];

   logic [vfv_pkg::CoordW-1:0]  x_ff, y_ff, z_ff;
   logic [vfv_pkg::MatW-1:0]    here_ff, here_in;
   logic [vfv_pkg::MaskW-1:0]   mask_ff, mask_in;
   logic                        rd_valid_ff;
   logic [vfv_pkg::StepW-1:0]   rd_step_ff;
   logic [vfv_pkg::MatW-1:0]    mem_rd_ff;
   logic [AW-1:0]               clr_addr_ff;
   logic                        rsp_valid_ff;
   logic [vfv_pkg::MaskW-1:0]   rsp_mask_ff;
   logic [vfv_pkg::MatW-1:0]    rsp_mat_ff;
   logic                        rsp_vis_ff;

   logic                        req_inside, q_inside;
   logic [CW-1:0]               cx, cy, cz;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic                        border;
   logic [vfv_pkg::MaskW-1:0]   face_bit;
   logic [vfv_pkg::MaskW-1:0]   final_mask;

   assign req_inside = (vfv_pkg::CmpW'(req_pos_x) < GridC) &&
                       (vfv_pkg::CmpW'(req_pos_y) < GridC) &&
                       (vfv_pkg::CmpW'(req_pos_z) < GridC);
   assign q_inside   = (vfv_pkg::CmpW'(x_ff) < GridC) &&
                       (vfv_pkg::CmpW'(y_ff) < GridC) &&
                       (vfv_pkg::CmpW'(z_ff) < GridC);

   assign cx = CW'(x_ff);
   assign cy = CW'(y_ff);
   assign cz = CW'(z_ff);
   assign wr_addr = {CW'(req_pos_z), CW'(req_pos_y), CW'(req_pos_x)};

   // neighbor address; a wrapped coordinate only shows up on a border face
   always_comb begin
      case (cmd.rd_step)
         vfv_pkg::STEP_POS_Z: rd_addr = {CW'(cz + One), cy, cx};
         vfv_pkg::STEP_NEG_Z: rd_addr = {CW'(cz - One), cy, cx};
         vfv_pkg::STEP_POS_X: rd_addr = {cz, cy, CW'(cx + One)};
         vfv_pkg::STEP_NEG_X: rd_addr = {cz, cy, CW'(cx - One)};
         vfv_pkg::STEP_POS_Y: rd_addr = {cz, CW'(cy + One), cx};
         vfv_pkg::STEP_NEG_Y: rd_addr = {cz, CW'(cy - One), cx};
         default:             rd_addr = {cz, cy, cx};
      endcase
   end

   always_comb begin
      case (rd_step_ff)
         vfv_pkg::STEP_POS_Z: begin
            border   = vfv_pkg::CmpW'(z_ff) == LastC;
            face_bit = vfv_pkg::FACE_POS_Z;
         end
         vfv_pkg::STEP_NEG_Z: begin
            border   = z_ff == '0;
            face_bit = vfv_pkg::FACE_NEG_Z;
         end
         vfv_pkg::STEP_POS_X: begin
            border   = vfv_pkg::CmpW'(x_ff) == LastC;
            face_bit = vfv_pkg::FACE_POS_X;
         end
         vfv_pkg::STEP_NEG_X: begin
            border   = x_ff == '0;
            face_bit = vfv_pkg::FACE_NEG_X;
         end
         vfv_pkg::STEP_POS_Y: begin
            border   = vfv_pkg::CmpW'(y_ff) == LastC;
            face_bit = vfv_pkg::FACE_POS_Y;
         end
         vfv_pkg::STEP_NEG_Y: begin
            border   = y_ff == '0;
            face_bit = vfv_pkg::FACE_NEG_Y;
         end
         default: begin
            border   = 1'b0;
            face_bit = '0;
         end
      endcase
   end

   always_comb begin
      here_in = here_ff;
      mask_in = mask_ff;
      if (rd_valid_ff) begin
         if (rd_step_ff == vfv_pkg::STEP_CENTER) begin
            here_in = q_inside ? mem_rd_ff : '0;
            mask_in = vfv_pkg::FACE_ALL;
         end else if (border || mem_rd_ff != '0) begin
            mask_in = mask_ff & ~face_bit;
         end
      end
   end

   assign final_mask = (here_ff != '0) ? mask_in : '0;

   // single-port store: clear and request writes never meet a read
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.write_voxel && req_inside) begin
         mem[wr_addr] <= req_material;
      end else if (cmd.rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
         z_ff <= req_pos_z;
      end
      here_ff    <= here_in;
      mask_ff    <= mask_in;
      rd_step_ff <= cmd.rd_step;
      if (cmd.rsp_load) begin
         rsp_mask_ff <= final_mask;
         rsp_mat_ff  <= here_ff;
         rsp_vis_ff  <= final_mask != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + One[0];
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = &clr_addr_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_face_mask      = rsp_mask_ff;
   assign rsp_voxel_material = rsp_mat_ff;
   assign rsp_visible        = rsp_vis_ff;

   a_visible_needs_solid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_vis_ff |-> rsp_mat_ff != '0 && rsp_mask_ff != '0)
      else $error("visible result without a solid voxel and an open face");

   a_empty_no_faces: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mat_ff == '0 |-> rsp_mask_ff == '0)
      else $error("empty voxel reported with exposed faces");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while still held");

endmodule

[rtl/vfv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_ctrl
// Sequencer: store clear after reset, request intake and the seven-read query walk.
// ----------------------------------------------------------------------------
module vfv_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_opcode,
   input  vfv_pkg::ctrl_status_type   status,
   output vfv_pkg::ctrl_cmd_type      cmd
);

   vfv_pkg::ctrl_state_type   state_ff, state_in;
   logic [vfv_pkg::StepW-1:0] step_ff, step_in;
   logic                      ready;
   logic                      take;

   always_comb begin
      case (state_ff)
         vfv_pkg::ST_IDLE: ready = 1'b1;
         vfv_pkg::ST_DONE: ready = status.rsp_free;
         default:          ready = 1'b0;
      endcase
   end

   assign take = req_valid && ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         vfv_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = vfv_pkg::ST_IDLE;
            end
         end
         vfv_pkg::ST_IDLE, vfv_pkg::ST_DONE: begin
            if (take && req_opcode == vfv_pkg::OP_QUERY) begin
               state_in = vfv_pkg::ST_READ;
               step_in  = vfv_pkg::STEP_CENTER;
            end else if (state_ff == vfv_pkg::ST_DONE && status.rsp_free) begin
               state_in = vfv_pkg::ST_IDLE;
            end
         end
         vfv_pkg::ST_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == vfv_pkg::STEP_LAST) begin
               state_in = vfv_pkg::ST_DONE;
            end
         end
         default: begin
            state_in = vfv_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd.ready       = ready;
      cmd.load_query  = take && req_opcode == vfv_pkg::OP_QUERY;
      cmd.write_voxel = take && req_opcode == vfv_pkg::OP_WRITE;
      cmd.clear_wr    = state_ff == vfv_pkg::ST_CLEAR;
      cmd.rd_en       = state_ff == vfv_pkg::ST_READ;
      cmd.rd_step     = step_ff;
      cmd.rsp_load    = state_ff == vfv_pkg::ST_DONE && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vfv_pkg::ST_CLEAR;
         step_ff  <= vfv_pkg::STEP_CENTER;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_no_intake_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == vfv_pkg::ST_CLEAR |-> !cmd.ready)
      else $error("request taken during store clear");

   a_query_starts_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.load_query |=> state_ff == vfv_pkg::ST_READ && step_ff == vfv_pkg::STEP_CENTER)
      else $error("query did not start at the center read");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == vfv_pkg::ST_READ && step_ff == vfv_pkg::STEP_LAST
      |=> state_ff == vfv_pkg::ST_DONE)
      else $error("read walk did not finish after the last neighbor");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !cmd.write_voxel && !cmd.clear_wr)
      else $error("store read and write in the same cycle");

endmodule

[rtl/voxel_face_visibility_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_visibility_core
// Hidden face culling over a cubic grid of 16-bit material ids.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries write beats (opcode 0: store material at pos) and query
//   beats (opcode 1). rsp_bus returns one beat per query: the exposed face
//   mask, the stored material and the visible flag. Writes return nothing;
//   coordinates outside the grid are dropped on write and read as empty.
//   A query walks seven reads of the single-port voxel store (center, then
//   +z, -z, +x, -x, +y, -y); req_bus.ready stays low during the walk, as
//   writes share that store port.
//   After reset the store is swept to empty one entry a cycle, covering all
//   2**(3*clog2(GRID_SIZE)) entries (32768 at the default size); req_bus.ready
//   stays low until the sweep ends.
//   The result sits in an output register: a query may start while an older
//   result waits, and the block holds the new one until rsp_bus.ready frees it.
// ----------------------------------------------------------------------------
module voxel_face_visibility_core #(
   parameter int GRID_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   vfv_req_if.sink     req_bus,
   vfv_rsp_if.source   rsp_bus
);

   vfv_pkg::ctrl_cmd_type    cmd;
   vfv_pkg::ctrl_status_type status;

   vfv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .status     (status),
      .cmd        (cmd)
   );

   vfv_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_pos_x          (req_bus.pos_x),
      .req_pos_y          (req_bus.pos_y),
      .req_pos_z          (req_bus.pos_z),
      .req_material       (req_bus.material),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_face_mask      (rsp_bus.face_mask),
      .rsp_voxel_material (rsp_bus.voxel_material),
      .rsp_visible        (rsp_bus.visible)
   );

   assign req_bus.ready = cmd.ready;

endmodule
